// ===== rtl/cbp_pkg.sv =====
// ----------------------------------------------------------------------------
// cbp_pkg: shared types and constants of the cubic Bezier point evaluator
// Holds the register map, the register reset values and the pipeline layout.
// ----------------------------------------------------------------------------
package cbp_pkg;

  // Register map: one control point coordinate per 32-bit word.
  localparam int NUM_REGS   = 8;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [2:0] {
    REG_START_X    = 3'd0,
    REG_START_Y    = 3'd1,
    REG_PULL_ONE_X = 3'd2,
    REG_PULL_ONE_Y = 3'd3,
    REG_PULL_TWO_X = 3'd4,
    REG_PULL_TWO_Y = 3'd5,
    REG_END_X      = 3'd6,
    REG_END_Y      = 3'd7
  } cfg_reg_e;

  localparam int RST_START_X    = 100;
  localparam int RST_START_Y    = 300;
  localparam int RST_PULL_ONE_X = 200;
  localparam int RST_PULL_ONE_Y = 100;
  localparam int RST_PULL_TWO_X = 400;
  localparam int RST_PULL_TWO_Y = 100;
  localparam int RST_END_X      = 500;
  localparam int RST_END_Y      = 300;

  // Pipeline layout. Each stage index names the register bank it loads.
  localparam int STAGES      = 9;
  localparam int ST_PARAM    = 0;  // clamped t and u = 1 - t
  localparam int ST_PROD     = 1;  // coordinate times u or t
  localparam int ST_LINE     = 2;  // u*P0 + 3t*P1 and 3u*P2 + t*P3
  localparam int ST_MUL1_PP  = 3;  // first scaling, partial products
  localparam int ST_MUL1_SUM = 4;  // first scaling, summed
  localparam int ST_MUL2_PP  = 5;  // second scaling, partial products
  localparam int ST_MUL2_SUM = 6;  // second scaling, summed
  localparam int ST_TOTAL    = 7;  // sum of both halves
  localparam int ST_OUT      = 8;  // truncated result, output register

  // Operand slice width of the split multiplier, small enough for one DSP cell.
  localparam int MUL_CHUNK_W = 24;

  typedef struct packed {
    logic [STAGES-1:0] en;
  } pipe_ctl_t;

  function automatic int reg_reset(cfg_reg_e r);
    int v;
    case (r)
      REG_START_X:    v = RST_START_X;
      REG_START_Y:    v = RST_START_Y;
      REG_PULL_ONE_X: v = RST_PULL_ONE_X;
      REG_PULL_ONE_Y: v = RST_PULL_ONE_Y;
      REG_PULL_TWO_X: v = RST_PULL_TWO_X;
      REG_PULL_TWO_Y: v = RST_PULL_TWO_Y;
      REG_END_X:      v = RST_END_X;
      REG_END_Y:      v = RST_END_Y;
      default:        v = 0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/cbp_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// cbp_cfg_regs: control point register file
// APB-style slave holding the eight control point coordinates.
// ----------------------------------------------------------------------------
module cbp_cfg_regs import cbp_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [CFG_ADDR_W-1:0]        paddr,
  input  logic [CFG_DATA_W-1:0]        pwdata,
  output logic [CFG_DATA_W-1:0]        prdata,
  output logic                         pready,
  output logic signed [COORD_BITS-1:0] coord_o [NUM_REGS]
);

  logic signed [COORD_BITS-1:0] regs_q [NUM_REGS];
  logic [2:0]                   idx;
  logic                         wr_en;

  assign idx    = paddr[CFG_ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        regs_q[i] <= COORD_BITS'(reg_reset(cfg_reg_e'(3'(i))));
      end
    end else if (wr_en) begin
      regs_q[idx] <= pwdata[COORD_BITS-1:0];
    end
  end

  // Reads return the coordinate sign-extended to the bus width.
  assign prdata  = CFG_DATA_W'(regs_q[idx]);
  assign coord_o = regs_q;

endmodule

// ===== rtl/cbp_wide_mul.sv =====
// ----------------------------------------------------------------------------
// cbp_wide_mul: two-stage split multiplier
// Multiplies a wide signed operand by a narrow unsigned one. The wide operand
// is cut into slices; the slice products are registered, then summed.
// ----------------------------------------------------------------------------
module cbp_wide_mul import cbp_pkg::*; #(
  parameter int A_W = 40,
  parameter int B_W = 17
) (
  input  logic                     clk_i,
  input  logic                     pp_en_i,
  input  logic                     sum_en_i,
  input  logic signed [A_W-1:0]    a_i,
  input  logic [B_W-1:0]           b_i,
  output logic signed [A_W+B_W-1:0] p_o
);

  localparam int N     = (A_W + MUL_CHUNK_W - 1) / MUL_CHUNK_W;
  localparam int EXT_W = N * MUL_CHUNK_W;
  localparam int PP_W  = MUL_CHUNK_W + B_W + 1;
  localparam int P_W   = A_W + B_W;

  logic signed [EXT_W-1:0] a_ext;
  logic signed [PP_W-1:0]  b_ext;
  logic signed [PP_W-1:0]  pp_d [N];
  logic signed [PP_W-1:0]  pp_q [N];
  logic signed [P_W-1:0]   sum_d;
  logic signed [P_W-1:0]   p_q;

  assign a_ext = EXT_W'(a_i);
  assign b_ext = $signed(PP_W'({1'b0, b_i}));

  // Lower slices are unsigned, the top slice carries the sign.
  for (genvar k = 0; k < N; k++) begin : g_slice
    if (k == N - 1) begin : g_top
      assign pp_d[k] = PP_W'($signed(a_ext[k*MUL_CHUNK_W +: MUL_CHUNK_W])) * b_ext;
    end else begin : g_low
      assign pp_d[k] = $signed(PP_W'({1'b0, a_ext[k*MUL_CHUNK_W +: MUL_CHUNK_W]})) * b_ext;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pp_en_i) begin
      pp_q <= pp_d;
    end
  end

  always_comb begin
    sum_d = '0;
    for (int k = 0; k < N; k++) begin
      sum_d = sum_d + (P_W'(pp_q[k]) <<< (k * MUL_CHUNK_W));
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_en_i) begin
      p_q <= sum_d;
    end
  end

  assign p_o = p_q;

endmodule

// ===== rtl/cbp_coord_path.sv =====
// ----------------------------------------------------------------------------
// cbp_coord_path: datapath for one coordinate
// Evaluates u^2*(u*P0 + 3t*P1) + t^2*(3u*P2 + t*P3) exactly and divides by
// 2^(3*FRAC_BITS), truncating toward zero.
// ----------------------------------------------------------------------------
module cbp_coord_path import cbp_pkg::*; #(
  parameter int FRAC_BITS  = 16,
  parameter int COORD_BITS = 12
) (
  input  logic                         clk_i,
  input  pipe_ctl_t                    ctl_i,
  input  logic [FRAC_BITS:0]           u0_i,
  input  logic [FRAC_BITS:0]           t0_i,
  input  logic [FRAC_BITS:0]           u2_i,
  input  logic [FRAC_BITS:0]           t2_i,
  input  logic [FRAC_BITS:0]           u4_i,
  input  logic [FRAC_BITS:0]           t4_i,
  input  logic signed [COORD_BITS-1:0] p0_i,
  input  logic signed [COORD_BITS-1:0] p1_i,
  input  logic signed [COORD_BITS-1:0] p2_i,
  input  logic signed [COORD_BITS-1:0] p3_i,
  output logic signed [COORD_BITS-1:0] point_o
);

  localparam int PR_W = FRAC_BITS + COORD_BITS;
  localparam int LR_W = PR_W + 2;
  localparam int M1_W = LR_W + FRAC_BITS + 1;
  localparam int M2_W = M1_W + FRAC_BITS + 1;
  localparam int SH   = 3 * FRAC_BITS;
  localparam logic signed [M2_W-1:0] BIAS = (M2_W'(1) << SH) - M2_W'(1);

  logic signed [PR_W-1:0]       u_e, t_e;
  logic signed [PR_W-1:0]       up0_q, tp1_q, up2_q, tp3_q;
  logic signed [LR_W-1:0]       lft_d, rgt_d, lft_q, rgt_q;
  logic signed [M1_W-1:0]       lft1, rgt1;
  logic signed [M2_W-1:0]       lft2, rgt2;
  logic signed [M2_W-1:0]       tot_q;
  logic signed [M2_W-1:0]       biased;
  logic signed [M2_W-1:0]       shr;
  logic signed [COORD_BITS-1:0] pt_q;

  assign u_e = $signed(PR_W'({1'b0, u0_i}));
  assign t_e = $signed(PR_W'({1'b0, t0_i}));

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[ST_PROD]) begin
      up0_q <= u_e * PR_W'(p0_i);
      tp1_q <= t_e * PR_W'(p1_i);
      up2_q <= u_e * PR_W'(p2_i);
      tp3_q <= t_e * PR_W'(p3_i);
    end
  end

  assign lft_d = LR_W'(up0_q) + LR_W'(tp1_q) + (LR_W'(tp1_q) <<< 1);
  assign rgt_d = LR_W'(tp3_q) + LR_W'(up2_q) + (LR_W'(up2_q) <<< 1);

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[ST_LINE]) begin
      lft_q <= lft_d;
      rgt_q <= rgt_d;
    end
  end

  cbp_wide_mul #(.A_W(LR_W), .B_W(FRAC_BITS + 1)) u_mul1_lft (
    .clk_i    (clk_i),
    .pp_en_i  (ctl_i.en[ST_MUL1_PP]),
    .sum_en_i (ctl_i.en[ST_MUL1_SUM]),
    .a_i      (lft_q),
    .b_i      (u2_i),
    .p_o      (lft1)
  );

  cbp_wide_mul #(.A_W(LR_W), .B_W(FRAC_BITS + 1)) u_mul1_rgt (
    .clk_i    (clk_i),
    .pp_en_i  (ctl_i.en[ST_MUL1_PP]),
    .sum_en_i (ctl_i.en[ST_MUL1_SUM]),
    .a_i      (rgt_q),
    .b_i      (t2_i),
    .p_o      (rgt1)
  );

  cbp_wide_mul #(.A_W(M1_W), .B_W(FRAC_BITS + 1)) u_mul2_lft (
    .clk_i    (clk_i),
    .pp_en_i  (ctl_i.en[ST_MUL2_PP]),
    .sum_en_i (ctl_i.en[ST_MUL2_SUM]),
    .a_i      (lft1),
    .b_i      (u4_i),
    .p_o      (lft2)
  );

  cbp_wide_mul #(.A_W(M1_W), .B_W(FRAC_BITS + 1)) u_mul2_rgt (
    .clk_i    (clk_i),
    .pp_en_i  (ctl_i.en[ST_MUL2_PP]),
    .sum_en_i (ctl_i.en[ST_MUL2_SUM]),
    .a_i      (rgt1),
    .b_i      (t4_i),
    .p_o      (rgt2)
  );

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[ST_TOTAL]) begin
      tot_q <= lft2 + rgt2;
    end
  end

  // A negative sum is biased up by one less than the divisor so that the
  // arithmetic shift truncates toward zero instead of toward minus infinity.
  assign biased = tot_q + (tot_q[M2_W-1] ? BIAS : M2_W'(0));
  assign shr    = biased >>> SH;

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[ST_OUT]) begin
      pt_q <= shr[COORD_BITS-1:0];
    end
  end

  assign point_o = pt_q;

endmodule

// ===== rtl/cubic_bezier_point.sv =====
// ----------------------------------------------------------------------------
// cubic_bezier_point: cubic Bezier curve point evaluator
// Throughput: one transfer per cycle while out_stall_i is low, set by the
// nine-stage pipeline in which every multiplier slice and adder stage has
// its own register.
// Reset: asynchronous, active low; clears all stage valid bits and loads the
// default control points (100,300) (200,100) (400,100) (500,300).
// ----------------------------------------------------------------------------
module cubic_bezier_point import cbp_pkg::*; #(
  parameter int FRAC_BITS  = 16,
  parameter int COORD_BITS = 12
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [CFG_ADDR_W-1:0]        paddr,
  input  logic [CFG_DATA_W-1:0]        pwdata,
  output logic [CFG_DATA_W-1:0]        prdata,
  output logic                         pready,
  // Parameter input channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [FRAC_BITS:0]           param_frac_i,
  // Curve point output channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [COORD_BITS-1:0] point_x_o,
  output logic signed [COORD_BITS-1:0] point_y_o
);

  // The value 1.0 in the parameter's fixed-point format.
  localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
  // The shared u and t values are needed up to the second scaling stage.
  localparam int UT_STAGES = ST_MUL2_PP;

  logic signed [COORD_BITS-1:0] coord [NUM_REGS];
  logic [STAGES-1:0]            valid_q;
  logic [STAGES-1:0]            ready;
  pipe_ctl_t                    ctl;
  logic [FRAC_BITS:0]           t_clamp;
  logic [FRAC_BITS:0]           u_q [UT_STAGES];
  logic [FRAC_BITS:0]           t_q [UT_STAGES];

  cbp_cfg_regs #(.COORD_BITS(COORD_BITS)) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coord_o (coord)
  );

  // Pipeline flow control. A stage may load when it is empty or when the
  // stage after it loads in the same cycle, so bubbles are squeezed out and
  // a new transfer is taken while the output result waits, if a stage is empty.
  always_comb begin
    ready[STAGES-1] = !valid_q[STAGES-1] || !out_stall_i;
    for (int k = STAGES - 2; k >= 0; k--) begin
      ready[k] = !valid_q[k] || ready[k+1];
    end
  end

  assign ctl.en     = ready;
  assign in_stall_o = !ready[ST_PARAM];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (ready[ST_PARAM]) begin
        valid_q[ST_PARAM] <= in_valid_i;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (ready[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  // A parameter above 1.0 is saturated to 1.0 before u = 1 - t is formed.
  assign t_clamp = (param_frac_i > ONE) ? ONE : param_frac_i;

  always_ff @(posedge clk_i) begin
    if (ready[ST_PARAM]) begin
      t_q[ST_PARAM] <= t_clamp;
      u_q[ST_PARAM] <= ONE - t_clamp;
    end
    for (int k = 1; k < UT_STAGES; k++) begin
      if (ready[k]) begin
        t_q[k] <= t_q[k-1];
        u_q[k] <= u_q[k-1];
      end
    end
  end

  // Both coordinates share the parameter pipeline and the flow control;
  // each has its own exact datapath.
  cbp_coord_path #(.FRAC_BITS(FRAC_BITS), .COORD_BITS(COORD_BITS)) u_path_x (
    .clk_i   (clk_i),
    .ctl_i   (ctl),
    .u0_i    (u_q[ST_PARAM]),
    .t0_i    (t_q[ST_PARAM]),
    .u2_i    (u_q[ST_LINE]),
    .t2_i    (t_q[ST_LINE]),
    .u4_i    (u_q[ST_MUL1_SUM]),
    .t4_i    (t_q[ST_MUL1_SUM]),
    .p0_i    (coord[REG_START_X]),
    .p1_i    (coord[REG_PULL_ONE_X]),
    .p2_i    (coord[REG_PULL_TWO_X]),
    .p3_i    (coord[REG_END_X]),
    .point_o (point_x_o)
  );

  cbp_coord_path #(.FRAC_BITS(FRAC_BITS), .COORD_BITS(COORD_BITS)) u_path_y (
    .clk_i   (clk_i),
    .ctl_i   (ctl),
    .u0_i    (u_q[ST_PARAM]),
    .t0_i    (t_q[ST_PARAM]),
    .u2_i    (u_q[ST_LINE]),
    .t2_i    (t_q[ST_LINE]),
    .u4_i    (u_q[ST_MUL1_SUM]),
    .t4_i    (t_q[ST_MUL1_SUM]),
    .p0_i    (coord[REG_START_Y]),
    .p1_i    (coord[REG_PULL_ONE_Y]),
    .p2_i    (coord[REG_PULL_TWO_Y]),
    .p3_i    (coord[REG_END_Y]),
    .point_o (point_y_o)
  );

  assign out_valid_o = valid_q[ST_OUT];

endmodule
